@@ hw/rtl/tld_pkg.sv @@
// ----------------------------------------------------------------------------
// tld_pkg
// Types and constants shared by the peak detector modules.
// ----------------------------------------------------------------------------
package tld_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int INDEX_W    = 12;
	localparam int DIST_W     = 12;
	localparam int COUNT_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// result queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LIMIT = 2'd2;

	localparam logic [DIST_W-1:0]  MIN_GAP_RST    = 12'd1;
	localparam logic [COUNT_W-1:0] PEAK_LIMIT_RST = 13'd4096;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} tld_in_t;

	typedef struct packed {
		logic                       peak_valid;
		logic [INDEX_W-1:0]         peak_index;
		logic signed [SAMPLE_W-1:0] peak_value;
		logic                       end_of_spectrum;
		logic [COUNT_W-1:0]         peak_total;
	} tld_out_t;

	// one queue entry: the words caused by one sample, first always present
	typedef struct packed {
		tld_out_t first;
		logic     has_second;
		tld_out_t second;
	} tld_entry_t;

	typedef struct packed {
		logic       push;
		tld_entry_t entry;
	} tld_push_t;

endpackage

@@ hw/rtl/tld_front.sv @@
// ----------------------------------------------------------------------------
// tld_front
// Sample window, local maximum test, pending peak and result classification.
// ----------------------------------------------------------------------------
module tld_front import tld_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tld_in_t               in_data,
	input  logic                  q_full,
	output tld_push_t             push
);

	localparam int POS_W = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W = (POS_W > DIST_W) ? POS_W : DIST_W;
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SAMPLES);

	logic signed [SAMPLE_W-1:0] threshold_q;
	logic [DIST_W-1:0]          min_gap_q;
	logic [COUNT_W-1:0]         peak_limit_q;

	logic signed [SAMPLE_W-1:0] older_q;
	logic signed [SAMPLE_W-1:0] middle_q;
	logic [POS_W-1:0]           pos_q;
	logic                       pend_q;
	logic [POS_W-1:0]           ppos_q;
	logic signed [SAMPLE_W-1:0] plvl_q;
	logic [COUNT_W-1:0]         cnt_q;

	logic                       take;
	logic                       in_range;
	logic                       is_max;
	logic [POS_W-1:0]           cand_pos;
	logic [POS_W-1:0]           gap;
	logic                       far;
	logic                       accept_peak;
	logic                       replace;
	logic                       emit_prev;
	logic                       n_pend;
	logic [POS_W-1:0]           n_ppos;
	logic signed [SAMPLE_W-1:0] n_plvl;
	logic [COUNT_W-1:0]         n_cnt;
	tld_out_t                   prev_res;
	tld_out_t                   end_res;

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			min_gap_q    <= MIN_GAP_RST;
			peak_limit_q <= PEAK_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:  threshold_q  <= cfg_data;
				REG_MIN_GAP:    min_gap_q    <= cfg_data[DIST_W-1:0];
				REG_PEAK_LIMIT: peak_limit_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_range = pos_q < MAX_POS;
		cand_pos = pos_q - POS_W'(1);
		gap      = cand_pos - ppos_q;
		is_max   = in_range && (pos_q >= POS_W'(2)) && (middle_q >= threshold_q) &&
		           (middle_q >= older_q) && (middle_q >= in_data.sample);
		far      = !pend_q || (CMP_W'(gap) >= CMP_W'(min_gap_q));
		accept_peak = is_max && far && (cnt_q < peak_limit_q);
		replace     = is_max && !far && (middle_q > plvl_q);
		emit_prev   = accept_peak && pend_q;

		n_pend = pend_q;
		n_ppos = ppos_q;
		n_plvl = plvl_q;
		n_cnt  = cnt_q;
		if (accept_peak) begin
			n_pend = 1'b1;
			n_ppos = cand_pos;
			n_plvl = middle_q;
			n_cnt  = cnt_q + COUNT_W'(1);
		end else if (replace) begin
			n_ppos = cand_pos;
			n_plvl = middle_q;
		end

		prev_res.peak_valid      = 1'b1;
		prev_res.peak_index      = INDEX_W'(ppos_q);
		prev_res.peak_value      = plvl_q;
		prev_res.end_of_spectrum = 1'b0;
		prev_res.peak_total      = n_cnt;

		if (n_pend) begin
			end_res.peak_valid = 1'b1;
			end_res.peak_index = INDEX_W'(n_ppos);
			end_res.peak_value = n_plvl;
			end_res.peak_total = n_cnt;
		end else begin
			end_res.peak_valid = 1'b0;
			end_res.peak_index = '0;
			end_res.peak_value = '0;
			end_res.peak_total = '0;
		end
		end_res.end_of_spectrum = 1'b1;

		push.push             = take && (emit_prev || in_data.last_sample);
		push.entry.first      = emit_prev ? prev_res : end_res;
		push.entry.has_second = emit_prev && in_data.last_sample;
		push.entry.second     = end_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			middle_q <= '0;
			pos_q    <= '0;
			pend_q   <= 1'b0;
			ppos_q   <= '0;
			plvl_q   <= '0;
			cnt_q    <= '0;
		end else if (take) begin
			if (in_data.last_sample) begin
				// close the spectrum
				older_q  <= '0;
				middle_q <= '0;
				pos_q    <= '0;
				pend_q   <= 1'b0;
				ppos_q   <= '0;
				plvl_q   <= '0;
				cnt_q    <= '0;
			end else begin
				pend_q <= n_pend;
				ppos_q <= n_ppos;
				plvl_q <= n_plvl;
				cnt_q  <= n_cnt;
				if (in_range) begin
					older_q  <= middle_q;
					middle_q <= in_data.sample;
					pos_q    <= pos_q + POS_W'(1);
				end
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_data.last_sample) |=> (pos_q == '0 && !pend_q && cnt_q == '0))
		else $error("spectrum state not cleared after last sample");

	a_count_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(take && accept_peak) |=> (cnt_q <= peak_limit_q || $past(in_data.last_sample)))
		else $error("accepted peaks exceed limit");

endmodule

@@ hw/rtl/tld_queue.sv @@
// ----------------------------------------------------------------------------
// tld_queue
// Short result queue that decouples the front from the output stage.
// ----------------------------------------------------------------------------
module tld_queue import tld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tld_push_t  push,
	input  logic       pop,
	output logic       full,
	output logic       empty,
	output tld_entry_t head
);

	tld_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign full   = count_q == QCNT_W'(QDEPTH);
	assign empty  = count_q == '0;
	assign head   = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			case ({push.push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !full)
		else $error("push into full queue");

	a_push_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push && do_pop) |=> $stable(count_q))
		else $error("queue count moved on push with pop");

endmodule

@@ hw/rtl/tld_back.sv @@
// ----------------------------------------------------------------------------
// tld_back
// Output stage: unpacks queue entries into result words, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module tld_back import tld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  tld_entry_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output tld_out_t   out_data
);

	logic     out_valid_q;
	tld_out_t out_q;
	logic     sec_valid_q;
	tld_out_t sec_q;
	logic     load;

	assign load      = !out_valid_q || !out_stall;
	assign q_pop     = load && !sec_valid_q && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !q_empty;
				sec_valid_q <= !q_empty && q_head.has_second;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_valid_q) begin
				out_q <= sec_q;
			end else if (!q_empty) begin
				out_q <= q_head.first;
				sec_q <= q_head.second;
			end
		end
	end

	a_second_behind_first: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> out_valid_q)
		else $error("second word held without a word on the output");

endmodule

@@ hw/rtl/thresholded_local_max_peak_detector.sv @@
// ----------------------------------------------------------------------------
// thresholded_local_max_peak_detector
// Takes one sample word per clock cycle while in_stall is low and reports
// local maxima that reach the threshold, spaced at least the minimum spacing
// apart, at most peak_limit per spectrum; a word with last_sample set closes
// the spectrum with an end word. The front holds the three-sample window and
// the pending peak and decides in the cycle of acceptance; a four-entry queue
// carries its results to the output register. A sample that causes two
// result words (a reported peak and the end word) loads the output twice,
// so the sustained rate is one sample per cycle unless the output stalls or
// such pairs arrive faster than the queue drains, in which case in_stall
// rises while the queue is full. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module thresholded_local_max_peak_detector import tld_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tld_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tld_out_t              out_data
);

	tld_push_t  push;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	tld_entry_t q_head;

	tld_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push)
	);

	tld_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (q_pop),
		.full  (q_full),
		.empty (q_empty),
		.head  (q_head)
	);

	tld_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
